/* sv/dra_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dra_pkg: shared types and constants of the descriptor range allocator
// Request and status codes, register indexes, sequencer states and the
// configuration register bundle.
// ----------------------------------------------------------------------------
package dra_pkg;

   // default sizes
   localparam int FREE_ENTRIES_DEF = 32;
   localparam int SLOT_BITS_DEF    = 16;

   // fixed field widths
   localparam int CAP_W     = 17;
   localparam int OFF_W     = 16;
   localparam int STRIDE_W  = 13;
   localparam int ADDR_W    = 64;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_W     = 2;
   localparam int STAT_W    = 2;

   localparam logic [CAP_W-1:0]    CAP_RESET    = 17'd65536;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd32;

   // request codes
   localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FREE    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CPU_BASE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GPU_BASE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VISIBLE  = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_SCAN,
      ST_A_PICK,
      ST_SHIFT_DN,
      ST_F_SCAN,
      ST_SHIFT_UP,
      ST_F_PUT,
      ST_M_START,
      ST_M_LOAD,
      ST_M_READ,
      ST_M_CMP,
      ST_G_MUL,
      ST_G_OUT
   } state_type;

   typedef struct packed {
      logic [CAP_W-1:0]    capacity;
      logic [OFF_W-1:0]    offset;
      logic [STRIDE_W-1:0] stride;
      logic [ADDR_W-1:0]   cpu_base;
      logic [ADDR_W-1:0]   gpu_base;
      logic                visible;
   } cfg_type;

endpackage
`default_nettype wire

/* sv/descriptor_range_allocator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// descriptor_range_allocator_unit: best-fit slot range allocator
// Free blocks live in a sorted table in RAM; allocate picks the smallest
// fitting block or bumps, free inserts in start order and merges neighbors.
//
// Channel   Ports                                   Moves
// request   start, busy, req_*                      one command word
// response  rsp_valid, rsp_*                        one result word
// config    csr_we, csr_index, csr_wdata            one register write
//
// A command is taken when start is high and busy is low; busy stays high
// until the result word, shown for one cycle with rsp_valid.
// Allocate scans the table, then shifts later entries down on an exact fit;
// free scans, shifts entries up, inserts, then walks the merge steps;
// the table RAM's single read port sets the pace, one entry per cycle.
// Clear and rejects answer from idle. Reset: synchronous, no RAM sweep.
// ----------------------------------------------------------------------------
module descriptor_range_allocator_unit #(
   parameter int FREE_ENTRIES = dra_pkg::FREE_ENTRIES_DEF,
   parameter int SLOT_BITS    = dra_pkg::SLOT_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [dra_pkg::REQ_W-1:0]     req_type,
   input  wire logic [SLOT_BITS:0]            req_block_count,
   input  wire logic [SLOT_BITS-1:0]          req_release_index,
   output logic                               rsp_valid,
   output logic [dra_pkg::STAT_W-1:0]         rsp_status,
   output logic [SLOT_BITS-1:0]               rsp_slot_index,
   output logic [dra_pkg::ADDR_W-1:0]         rsp_cpu_address,
   output logic [dra_pkg::ADDR_W-1:0]         rsp_gpu_address,
   input  wire logic                          csr_we,
   input  wire logic [dra_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dra_pkg::ADDR_W-1:0]    csr_wdata
);
   import dra_pkg::*;

   localparam int SB     = SLOT_BITS;
   localparam int LEN_W  = SLOT_BITS + 1;
   localparam int ENT_W  = SB + LEN_W;
   localparam int IDX_W  = $clog2(FREE_ENTRIES);
   localparam int CNT_W  = $clog2(FREE_ENTRIES + 1);
   localparam int CMP_W  = (CAP_W > LEN_W) ? CAP_W : LEN_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FREE_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

   // control registers
   state_type         state_ff, state_in, ret_ff, ret_in;
   cfg_type           cfg_ff;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [LEN_W-1:0]  bump_ff, bump_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              iss_ff, iss_in;
   logic              dv_ff, dv_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [IDX_W-1:0]  d_idx_ff, d_idx_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [LEN_W-1:0]  best_len_ff, best_len_in;
   logic [SB-1:0]     best_start_ff, best_start_in;
   logic [LEN_W-1:0]  req_cnt_ff, req_cnt_in;
   logic [SB-1:0]     req_start_ff, req_start_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  walk_ff, walk_in;
   logic [SB-1:0]     cur_start_ff, cur_start_in;
   logic [LEN_W-1:0]  cur_len_ff, cur_len_in;
   logic [SB-1:0]     grant_ff, grant_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SB-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [ADDR_W-1:0] rsp_cpu_ff, rsp_cpu_in;
   logic [ADDR_W-1:0] rsp_gpu_ff, rsp_gpu_in;

   // table RAM port
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [ENT_W-1:0]  wr_data, rd_data;
   logic [SB-1:0]     rd_start;
   logic [LEN_W-1:0]  rd_len;

   // address unit
   logic [ADDR_W-1:0] cpu_addr, gpu_addr;

   // shared conditions
   logic [CMP_W-1:0]  cap_wide, lim_wide;
   logic [LEN_W-1:0]  eff_cap;
   logic [LEN_W:0]    free_end, bump_end, cur_end;
   logic              free_over, bump_fits, exact, adjacent, stream_done;
   logic [CNT_W-1:0]  used_m1, best_p1, walk_p1, walk_p2;

   assign rd_start = rd_data[ENT_W-1:LEN_W];
   assign rd_len   = rd_data[LEN_W-1:0];

   // cap the region at the slot space
   assign cap_wide = CMP_W'(cfg_ff.capacity);
   assign lim_wide = CMP_W'(1) << SB;
   assign eff_cap  = (cap_wide > lim_wide) ? LEN_W'(lim_wide) : LEN_W'(cap_wide);

   assign free_end  = (LEN_W+1)'(req_release_index) + (LEN_W+1)'(req_block_count);
   assign free_over = free_end > (LEN_W+1)'(eff_cap);
   assign bump_end  = (LEN_W+1)'(bump_ff) + (LEN_W+1)'(req_cnt_ff);
   assign bump_fits = bump_end <= (LEN_W+1)'(eff_cap);
   assign exact     = best_len_ff == req_cnt_ff;
   assign cur_end   = (LEN_W+1)'(cur_start_ff) + (LEN_W+1)'(cur_len_ff);
   assign adjacent  = cur_end == (LEN_W+1)'(rd_start);

   assign used_m1     = used_ff - CNT_ONE;
   assign best_p1     = CNT_W'(best_idx_ff) + CNT_ONE;
   assign walk_p1     = walk_ff + CNT_ONE;
   assign walk_p2     = walk_ff + CNT_TWO;
   assign stream_done = !iss_ff && !dv_ff;

   dra_ram #(
      .WIDTH (ENT_W),
      .DEPTH (FREE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dra_addr #(
      .SLOT_BITS (SLOT_BITS)
   ) u_addr (
      .clock       (clock),
      .cfg         (cfg_ff),
      .slot        (grant_ff),
      .cpu_address (cpu_addr),
      .gpu_address (gpu_addr)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_type)
                  REQ_ALLOC: begin
                     if (req_block_count != '0) begin
                        state_in = (used_ff != '0) ? ST_A_SCAN : ST_A_PICK;
                     end
                  end
                  REQ_FREE: begin
                     if (req_block_count != '0 && !free_over && used_ff != CNT_FULL) begin
                        state_in = (used_ff != '0) ? ST_F_SCAN : ST_F_PUT;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_A_SCAN: begin
            if (stream_done) state_in = ST_A_PICK;
         end
         ST_A_PICK: begin
            if (found_ff) begin
               state_in = (exact && best_p1 < used_ff) ? ST_SHIFT_DN : ST_G_MUL;
            end else begin
               state_in = bump_fits ? ST_G_MUL : ST_IDLE;
            end
         end
         ST_SHIFT_DN: begin
            if (stream_done) state_in = ret_ff;
         end
         ST_F_SCAN: begin
            if (stream_done) state_in = (pos_ff < used_ff) ? ST_SHIFT_UP : ST_F_PUT;
         end
         ST_SHIFT_UP: begin
            if (stream_done) state_in = ST_F_PUT;
         end
         ST_F_PUT:   state_in = ST_M_START;
         ST_M_START: state_in = (used_ff < CNT_TWO) ? ST_IDLE : ST_M_LOAD;
         ST_M_LOAD:  state_in = ST_M_READ;
         ST_M_READ:  state_in = (walk_p1 < used_ff) ? ST_M_CMP : ST_IDLE;
         ST_M_CMP: begin
            state_in = (adjacent && walk_p2 < used_ff) ? ST_SHIFT_DN : ST_M_READ;
         end
         ST_G_MUL:   state_in = ST_G_OUT;
         ST_G_OUT:   state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and table access
   always_comb begin
      ret_in        = ret_ff;
      used_in       = used_ff;
      bump_in       = bump_ff;
      idx_in        = idx_ff;
      iss_in        = iss_ff;
      dv_in         = 1'b0;
      found_in      = found_ff;
      d_idx_in      = idx_ff[IDX_W-1:0];
      best_idx_in   = best_idx_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      req_cnt_in    = req_cnt_ff;
      req_start_in  = req_start_ff;
      pos_in        = pos_ff;
      walk_in       = walk_ff;
      cur_start_in  = cur_start_ff;
      cur_len_in    = cur_len_ff;
      grant_in      = grant_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_slot_in   = '0;
      rsp_cpu_in    = '0;
      rsp_gpu_in    = '0;
      wr_en         = 1'b0;
      wr_addr       = d_idx_ff;
      wr_data       = rd_data;
      rd_addr       = idx_ff[IDX_W-1:0];

      // stream reads upward
      if ((state_ff == ST_A_SCAN || state_ff == ST_F_SCAN || state_ff == ST_SHIFT_DN)
          && iss_ff) begin
         dv_in = 1'b1;
         if (idx_ff == used_m1) iss_in = 1'b0;
         else                   idx_in = idx_ff + CNT_ONE;
      end
      // stream reads downward
      if (state_ff == ST_SHIFT_UP && iss_ff) begin
         dv_in = 1'b1;
         if (idx_ff == pos_ff) iss_in = 1'b0;
         else                  idx_in = idx_ff - CNT_ONE;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_cnt_in   = req_block_count;
               req_start_in = req_release_index;
               found_in     = 1'b0;
               idx_in       = '0;
               pos_in       = used_ff;
               case (req_type)
                  REQ_CLEAR: begin
                     used_in      = '0;
                     bump_in      = '0;
                     rsp_valid_in = 1'b1;
                  end
                  REQ_ALLOC: begin
                     if (req_block_count == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_IGNORED;
                     end else begin
                        iss_in = used_ff != '0;
                     end
                  end
                  REQ_FREE: begin
                     if (req_block_count == '0 || free_over) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_IGNORED;
                     end else if (used_ff == CNT_FULL) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_FULL;
                     end else begin
                        iss_in = used_ff != '0;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_IGNORED;
                  end
               endcase
            end
         end
         ST_A_SCAN: begin
            // keep the smallest fitting block, earliest on ties
            if (dv_ff && rd_len >= req_cnt_ff && (!found_ff || rd_len < best_len_ff)) begin
               found_in      = 1'b1;
               best_idx_in   = d_idx_ff;
               best_len_in   = rd_len;
               best_start_in = rd_start;
            end
         end
         ST_A_PICK: begin
            if (found_ff) begin
               grant_in = best_start_ff;
               if (exact) begin
                  if (best_p1 < used_ff) begin
                     idx_in = best_p1;
                     iss_in = 1'b1;
                     ret_in = ST_G_MUL;
                  end else begin
                     used_in = used_m1;
                  end
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = best_idx_ff;
                  wr_data = {SB'(best_start_ff + SB'(req_cnt_ff)), best_len_ff - req_cnt_ff};
               end
            end else if (bump_fits) begin
               grant_in = bump_ff[SB-1:0];
               bump_in  = LEN_W'(bump_end);
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_NOSPACE;
            end
         end
         ST_SHIFT_DN: begin
            // move each entry one place down, drop the last
            if (dv_ff) begin
               wr_en   = 1'b1;
               wr_addr = d_idx_ff - IDX_W'(1);
            end
            if (stream_done) used_in = used_m1;
         end
         ST_F_SCAN: begin
            // first entry at or above the new start
            if (dv_ff && !found_ff && rd_start >= req_start_ff) begin
               found_in = 1'b1;
               pos_in   = CNT_W'(d_idx_ff);
            end
            if (stream_done && pos_ff < used_ff) begin
               idx_in = used_m1;
               iss_in = 1'b1;
            end
         end
         ST_SHIFT_UP: begin
            if (dv_ff) begin
               wr_en   = 1'b1;
               wr_addr = d_idx_ff + IDX_W'(1);
            end
         end
         ST_F_PUT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[IDX_W-1:0];
            wr_data = {req_start_ff, req_cnt_ff};
            used_in = used_ff + CNT_ONE;
         end
         ST_M_START: begin
            rd_addr = '0;
            walk_in = '0;
            if (used_ff < CNT_TWO) rsp_valid_in = 1'b1;
         end
         ST_M_LOAD: begin
            cur_start_in = rd_start;
            cur_len_in   = rd_len;
         end
         ST_M_READ: begin
            rd_addr = walk_p1[IDX_W-1:0];
            if (!(walk_p1 < used_ff)) rsp_valid_in = 1'b1;
         end
         ST_M_CMP: begin
            // merge exactly adjacent pair, else step on
            if (adjacent) begin
               cur_len_in = cur_len_ff + rd_len;
               wr_en      = 1'b1;
               wr_addr    = walk_ff[IDX_W-1:0];
               wr_data    = {cur_start_ff, LEN_W'(cur_len_ff + rd_len)};
               if (walk_p2 < used_ff) begin
                  idx_in = walk_p2;
                  iss_in = 1'b1;
                  ret_in = ST_M_READ;
               end else begin
                  used_in = used_m1;
               end
            end else begin
               cur_start_in = rd_start;
               cur_len_in   = rd_len;
               walk_in      = walk_p1;
            end
         end
         ST_G_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_slot_in  = grant_ff;
            rsp_cpu_in   = cpu_addr;
            rsp_gpu_in   = gpu_addr;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         used_ff      <= '0;
         bump_ff      <= '0;
         idx_ff       <= '0;
         iss_ff       <= 1'b0;
         dv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         used_ff      <= used_in;
         bump_ff      <= bump_in;
         idx_ff       <= idx_in;
         iss_ff       <= iss_in;
         dv_ff        <= dv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      d_idx_ff      <= d_idx_in;
      best_idx_ff   <= best_idx_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      req_cnt_ff    <= req_cnt_in;
      req_start_ff  <= req_start_in;
      pos_ff        <= pos_in;
      walk_ff       <= walk_in;
      cur_start_ff  <= cur_start_in;
      cur_len_ff    <= cur_len_in;
      grant_ff      <= grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_cpu_ff    <= rsp_cpu_in;
      rsp_gpu_ff    <= rsp_gpu_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity <= CAP_RESET;
         cfg_ff.offset   <= '0;
         cfg_ff.stride   <= STRIDE_RESET;
         cfg_ff.cpu_base <= '0;
         cfg_ff.gpu_base <= '0;
         cfg_ff.visible  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY: cfg_ff.capacity <= csr_wdata[CAP_W-1:0];
            CSR_OFFSET:   cfg_ff.offset   <= csr_wdata[OFF_W-1:0];
            CSR_STRIDE:   cfg_ff.stride   <= csr_wdata[STRIDE_W-1:0];
            CSR_CPU_BASE: cfg_ff.cpu_base <= csr_wdata;
            CSR_GPU_BASE: cfg_ff.gpu_base <= csr_wdata;
            CSR_VISIBLE:  cfg_ff.visible  <= csr_wdata[0];
            default:      cfg_ff.visible  <= cfg_ff.visible;
         endcase
      end
   end

   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_cpu_address = rsp_cpu_ff;
   assign rsp_gpu_address = rsp_gpu_ff;

   // checks
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word while sequencer busy");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_FULL)
      else $error("free table count beyond depth");

   a_cmd_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("command taken without work or result");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |->
         (rsp_slot_index == '0 && rsp_cpu_address == '0 && rsp_gpu_address == '0))
      else $error("failed result carries nonzero fields");

endmodule
`default_nettype wire

/* sv/dra_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dra_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dra_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write, then read registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

/* sv/dra_addr.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dra_addr: slot address unit
// Registers (offset + slot) * stride, adds CPU and (if visible) GPU bases.
// ----------------------------------------------------------------------------
module dra_addr #(
   parameter int SLOT_BITS = 16
) (
   input  wire logic                    clock,
   input  wire dra_pkg::cfg_type        cfg,
   input  wire logic [SLOT_BITS-1:0]    slot,
   output logic [dra_pkg::ADDR_W-1:0]   cpu_address,
   output logic [dra_pkg::ADDR_W-1:0]   gpu_address
);
   import dra_pkg::*;

   localparam int SUM_W  = ((SLOT_BITS > OFF_W) ? SLOT_BITS : OFF_W) + 1;
   localparam int PROD_W = SUM_W + STRIDE_W;

   logic [SUM_W-1:0]  heap_slot;
   logic [PROD_W-1:0] prod_ff;

   // heap slot times stride, registered
   assign heap_slot = SUM_W'(cfg.offset) + SUM_W'(slot);

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(heap_slot) * PROD_W'(cfg.stride);
   end

   // add bases, wrap at 64 bits
   assign cpu_address = cfg.cpu_base + ADDR_W'(prod_ff);
   assign gpu_address = cfg.visible ? (cfg.gpu_base + ADDR_W'(prod_ff)) : '0;

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the descriptor range allocator unit
// Drives allocate, free and clear command words through the start/busy
// handshake, predicts each result word from a behavioral copy of the free
// table and bump pointer, and compares field by field. Registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
   import dra_pkg::*;

   localparam int NFREE  = 32;
   localparam int SBITS  = 16;
   localparam int NRAND  = 1000;
   localparam int LIMIT  = 2000000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [REQ_W-1:0]     req_type = REQ_ALLOC;
   logic [SBITS:0]       req_block_count = '0;
   logic [SBITS-1:0]     req_release_index = '0;
   logic                 rsp_valid;
   logic [STAT_W-1:0]    rsp_status;
   logic [SBITS-1:0]     rsp_slot_index;
   logic [ADDR_W-1:0]    rsp_cpu_address;
   logic [ADDR_W-1:0]    rsp_gpu_address;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CAPACITY;
   logic [ADDR_W-1:0]    csr_wdata = '0;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [SBITS-1:0]  slot;
      logic [ADDR_W-1:0] cpu;
      logic [ADDR_W-1:0] gpu;
   } grant_word_type;

   typedef struct {
      logic [REQ_W-1:0] kind;
      logic [SBITS:0]   count;
      logic [SBITS-1:0] index;
      bit               typed;
      grant_word_type   want;
   } cmd_row_type;

   // predictor copy of the allocator
   cfg_type        cfg;
   logic [SBITS:0] bump_mark;
   int             used;
   logic [SBITS:0] blk_start [NFREE];
   logic [SBITS:0] blk_len [NFREE];

   grant_word_type pending_grants[$];
   bit             failed = 1'b0;
   int             cycles = 0;

   descriptor_range_allocator_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_block_count(req_block_count),
      .req_release_index(req_release_index), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_slot_index(rsp_slot_index),
      .rsp_cpu_address(rsp_cpu_address), .rsp_gpu_address(rsp_gpu_address),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic void remove_block(int pos);
      for (int i = pos; i + 1 < used; i++) begin
         blk_start[i] = blk_start[i+1];
         blk_len[i]   = blk_len[i+1];
      end
      used--;
   endfunction

   function automatic grant_word_type grant_of(logic [SBITS:0] slot);
      grant_word_type g;
      logic [ADDR_W-1:0] off;
      off = (ADDR_W'(cfg.offset) + ADDR_W'(slot)) * ADDR_W'(cfg.stride);
      g.status = STAT_OK;
      g.slot   = slot[SBITS-1:0];
      g.cpu    = cfg.cpu_base + off;
      g.gpu    = cfg.visible ? cfg.gpu_base + off : '0;
      return g;
   endfunction

   // compute the result word of one command and advance the table
   function automatic grant_word_type allocate_predict(logic [REQ_W-1:0] kind,
                                                       logic [SBITS:0] count,
                                                       logic [SBITS-1:0] index);
      grant_word_type g;
      logic [SBITS+1:0] cap;
      int best;
      int pos;
      logic [SBITS:0] slot;
      g = '0;
      cap = ((SBITS+2)'(cfg.capacity) > (SBITS+2)'(1 << SBITS)) ?
            (SBITS+2)'(1 << SBITS) : (SBITS+2)'(cfg.capacity);
      if (kind == REQ_CLEAR) begin
         bump_mark = '0;
         used = 0;
         return g;
      end
      if (kind != REQ_ALLOC && kind != REQ_FREE || count == 0) begin
         g.status = STAT_IGNORED;
         return g;
      end
      if (kind == REQ_ALLOC) begin
         best = -1;
         for (int i = 0; i < used; i++)
            if (blk_len[i] >= count && (best < 0 || blk_len[i] < blk_len[best]))
               best = i;
         if (best >= 0) begin
            slot = blk_start[best];
            if (blk_len[best] == count) remove_block(best);
            else begin
               blk_start[best] += count;
               blk_len[best]   -= count;
            end
            return grant_of(slot);
         end
         if ((SBITS+2)'(bump_mark) + count <= cap) begin
            slot = bump_mark;
            bump_mark += count;
            return grant_of(slot);
         end
         g.status = STAT_NOSPACE;
         return g;
      end
      if ((SBITS+2)'(index) + count > cap) begin
         g.status = STAT_IGNORED;
         return g;
      end
      if (used >= NFREE) begin
         g.status = STAT_FULL;
         return g;
      end
      pos = 0;
      while (pos < used && blk_start[pos] < index) pos++;
      for (int i = used; i > pos; i--) begin
         blk_start[i] = blk_start[i-1];
         blk_len[i]   = blk_len[i-1];
      end
      blk_start[pos] = (SBITS+1)'(index);
      blk_len[pos]   = count;
      used++;
      // merge exactly adjacent neighbors
      pos = 0;
      while (pos + 1 < used) begin
         if (blk_start[pos] + blk_len[pos] == blk_start[pos+1]) begin
            blk_len[pos] += blk_len[pos+1];
            remove_block(pos + 1);
         end else pos++;
      end
      return g;
   endfunction

   // check each result word against the oldest expectation
   always @(posedge clock) begin
      grant_word_type w;
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected result word status=%0d", $time, rsp_status);
            failed = 1'b1;
         end else begin
            w = pending_grants.pop_front();
            if (rsp_status !== w.status) begin
               $display("%0t: status exp %0d got %0d", $time, w.status, rsp_status);
               failed = 1'b1;
            end
            if (rsp_slot_index !== w.slot) begin
               $display("%0t: slot exp %0d got %0d", $time, w.slot, rsp_slot_index);
               failed = 1'b1;
            end
            if (rsp_cpu_address !== w.cpu) begin
               $display("%0t: cpu exp %h got %h", $time, w.cpu, rsp_cpu_address);
               failed = 1'b1;
            end
            if (rsp_gpu_address !== w.gpu) begin
               $display("%0t: gpu exp %h got %h", $time, w.gpu, rsp_gpu_address);
               failed = 1'b1;
            end
         end
      end
   end

   // one register write, with the write enable dropped again afterwards
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_CAPACITY: cfg.capacity = val[CAP_W-1:0];
         CSR_OFFSET:   cfg.offset   = val[OFF_W-1:0];
         CSR_STRIDE:   cfg.stride   = val[STRIDE_W-1:0];
         CSR_CPU_BASE: cfg.cpu_base = val;
         CSR_GPU_BASE: cfg.gpu_base = val;
         CSR_VISIBLE:  cfg.visible  = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // present one command word, hold it until taken, then drop start
   task automatic issue(logic [REQ_W-1:0] kind, logic [SBITS:0] count,
                        logic [SBITS-1:0] index, bit typed, grant_word_type want);
      grant_word_type g;
      start             <= 1'b1;
      req_type          <= kind;
      req_block_count   <= count;
      req_release_index <= index;
      do @(posedge clock); while (busy);
      g = allocate_predict(kind, count, index);
      if (typed && g !== want) begin
         $display("%0t: table row exp %h predicted %h", $time, want, g);
         failed = 1'b1;
      end
      pending_grants.push_back(g);
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // random command mix: mostly allocates and frees, some noise
   task automatic random_cmds(int n, int maxc);
      logic [SBITS:0] c;
      logic [SBITS-1:0] ix;
      logic [REQ_W-1:0] k;
      int r;
      int burst;
      burst = 0;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         c = (r % 10 == 0) ? (SBITS+1)'($urandom_range(1 << SBITS)) :
                             (SBITS+1)'($urandom_range(maxc));
         ix = SBITS'($urandom);
         if (r < 45) k = REQ_ALLOC;
         else if (r < 90) k = REQ_FREE;
         else if (r < 93) k = REQ_CLEAR;
         else k = REQ_UNKNOWN;
         // free ranges that tend to lie within allocated space
         if (k == REQ_FREE && r % 3 != 0 && bump_mark > 0)
            ix = SBITS'($urandom_range(bump_mark - 1));
         issue(k, c, ix, 1'b0, '0);
         if (burst == 0) begin
            burst = $urandom_range(20);
            repeat ($urandom_range(6)) @(posedge clock);
         end else burst--;
      end
   endtask

   cmd_row_type dir_rows[$];

   initial begin
      grant_word_type z;
      cfg.capacity = CAP_RESET;
      cfg.offset   = '0;
      cfg.stride   = STRIDE_RESET;
      cfg.cpu_base = '0;
      cfg.gpu_base = '0;
      cfg.visible  = 1'b0;
      bump_mark = '0;
      used = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; typed rows are readable from reset values
      z = '0;
      dir_rows.push_back('{REQ_ALLOC, 17'd4, 16'd0, 1'b1, '{STAT_OK, 16'd0, 64'd0, 64'd0}});
      dir_rows.push_back('{REQ_ALLOC, 17'd2, 16'd0, 1'b1, '{STAT_OK, 16'd4, 64'd128, 64'd0}});
      dir_rows.push_back('{REQ_ALLOC, 17'd0, 16'd0, 1'b1,
                           '{STAT_IGNORED, 16'd0, 64'd0, 64'd0}});
      dir_rows.push_back('{REQ_UNKNOWN, 17'd5, 16'hFFFF, 1'b1,
                           '{STAT_IGNORED, 16'd0, 64'd0, 64'd0}});
      dir_rows.push_back('{REQ_FREE, 17'd0, 16'd1, 1'b1, '{STAT_IGNORED, 16'd0, 64'd0, 64'd0}});
      dir_rows.push_back('{REQ_FREE, 17'd2, 16'hFFFF, 1'b1,
                           '{STAT_IGNORED, 16'd0, 64'd0, 64'd0}});
      dir_rows.push_back('{REQ_FREE, 17'd1, 16'hFFFF, 1'b1, '{STAT_OK, 16'd0, 64'd0, 64'd0}});
      dir_rows.push_back('{REQ_FREE, 17'd2, 16'd0, 1'b0, z});
      dir_rows.push_back('{REQ_FREE, 17'd2, 16'd2, 1'b0, z});
      dir_rows.push_back('{REQ_ALLOC, 17'd1, 16'd0, 1'b0, z});
      dir_rows.push_back('{REQ_ALLOC, 17'd3, 16'd0, 1'b0, z});
      dir_rows.push_back('{REQ_ALLOC, 17'h1FFFF, 16'd0, 1'b1,
                           '{STAT_NOSPACE, 16'd0, 64'd0, 64'd0}});
      dir_rows.push_back('{REQ_CLEAR, 17'h1FFFF, 16'hFFFF, 1'b1,
                           '{STAT_OK, 16'd0, 64'd0, 64'd0}});
      dir_rows.push_back('{REQ_ALLOC, 17'd65536, 16'd0, 1'b1, '{STAT_OK, 16'd0, 64'd0, 64'd0}});
      dir_rows.push_back('{REQ_ALLOC, 17'd1, 16'd0, 1'b1, '{STAT_NOSPACE, 16'd0, 64'd0, 64'd0}});
      dir_rows.push_back('{REQ_FREE, 17'd65536, 16'd0, 1'b1, '{STAT_OK, 16'd0, 64'd0, 64'd0}});
      dir_rows.push_back('{REQ_CLEAR, 17'd0, 16'd0, 1'b1, '{STAT_OK, 16'd0, 64'd0, 64'd0}});
      foreach (dir_rows[i])
         issue(dir_rows[i].kind, dir_rows[i].count, dir_rows[i].index,
               dir_rows[i].typed, dir_rows[i].want);
      drain();

      // fill the free table with isolated blocks, then hit it when full
      for (int i = 0; i < NFREE + 2; i++)
         issue(REQ_FREE, 17'd1, 16'(2 * i), 1'b0, '0);
      issue(REQ_FREE, 17'd1, 16'd1, 1'b0, '0);
      issue(REQ_CLEAR, '0, '0, 1'b0, '0);
      drain();

      // phase: extreme registers, visible, small capacity
      write_reg(CSR_CAPACITY, 64'd200);
      write_reg(CSR_OFFSET, 64'hFFFF);
      write_reg(CSR_STRIDE, 64'd4096);
      write_reg(CSR_CPU_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_GPU_BASE, 64'h8000_0000_0000_0000);
      write_reg(CSR_VISIBLE, 64'd1);
      random_cmds(300, 12);
      issue(REQ_CLEAR, '0, '0, 1'b0, '0);
      drain();

      // phase: minimum capacity and stride, random bases
      write_reg(CSR_CAPACITY, 64'd1);
      write_reg(CSR_OFFSET, 64'd0);
      write_reg(CSR_STRIDE, 64'd1);
      write_reg(CSR_CPU_BASE, {$urandom, $urandom});
      write_reg(CSR_GPU_BASE, {$urandom, $urandom});
      random_cmds(60, 2);
      issue(REQ_CLEAR, '0, '0, 1'b0, '0);
      drain();

      // phase: capacity above the slot range, hidden GPU addresses
      write_reg(CSR_CAPACITY, 64'h1FFFF);
      write_reg(CSR_OFFSET, 64'($urandom_range(65535)));
      write_reg(CSR_STRIDE, 64'($urandom_range(1, 4096)));
      write_reg(CSR_VISIBLE, 64'd0);
      random_cmds(300, 3000);
      drain();

      // phase: mid capacity, visible again
      write_reg(CSR_CAPACITY, 64'd1000);
      write_reg(CSR_VISIBLE, 64'd1);
      issue(REQ_CLEAR, '0, '0, 1'b0, '0);
      random_cmds(NRAND - 660, 40);

      drain();
      if (!failed && pending_grants.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
